FILE: src/lrukv_pkg.sv
// lrukv_pkg: shared types and constants for the lru key-value cache
// holds field widths, operation codes and the structs passed along the cell chain
// no dependencies
package lrukv_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CFG_W   = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET  = 5'd16;
  localparam logic [VALUE_W-1:0] MISS_VALUE = {VALUE_W{1'b1}};

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // request broadcast to every cell
  typedef struct packed {
    logic               is_put;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] write_value;
  } lrukv_req_t;

  // update command broadcast once the chain has resolved the lookup
  typedef struct packed {
    logic go;
    logic hit;
    logic insert;
    logic full;
  } lrukv_upd_t;

  // lookup results rippling from cell to cell
  typedef struct packed {
    logic               claimed;
    logic               hit;
    logic [VALUE_W-1:0] value;
  } lrukv_link_t;

endpackage

FILE: src/lrukv_cell.sv
// lrukv_cell: one cache entry with key, value, valid flag and recency rank
// compares the key, passes hit data and the free-slot token to the next cell
// depends on lrukv_pkg
module lrukv_cell
  import lrukv_pkg::*;
#(
  parameter int RANK_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lrukv_req_t        req,
  input  lrukv_upd_t        upd,
  input  logic [RANK_W-1:0] limit,
  input  logic [RANK_W-1:0] last_rank,
  input  lrukv_link_t       link_in,
  output lrukv_link_t       link_out,
  input  logic [RANK_W-1:0] rank_in,
  output logic [RANK_W-1:0] rank_out,
  output logic              occupied
);

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;
  logic [RANK_W-1:0]  rank;

  logic match;
  logic oldest;
  logic free_here;
  logic sel;
  logic age;

  assign match     = valid && (key == req.key);
  assign oldest    = valid && (rank == last_rank);
  assign free_here = !valid && !link_in.claimed;

  assign link_out.claimed = link_in.claimed || !valid;
  assign link_out.hit     = link_in.hit || match;
  assign link_out.value   = link_in.value | (match ? value : '0);
  assign rank_out         = rank_in | (match ? rank : '0);
  assign occupied         = valid;

  always_comb begin
    if (upd.hit) begin
      sel = match;
    end else if (upd.insert) begin
      sel = upd.full ? oldest : free_here;
    end else begin
      sel = 1'b0;
    end
  end

  // on a hit, everything ranked newer than the promoted entry ages by one; on an insert, every other valid entry ages
  assign age = valid && !sel && (upd.hit || upd.insert) && (upd.insert || (rank < limit));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.go && sel) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.go) begin
      if (sel) begin
        rank <= '0;
        if (upd.insert) begin
          key <= req.key;
        end
        if (req.is_put) begin
          value <= req.write_value;
        end
      end else if (age) begin
        rank <= rank + RANK_W'(1);
      end
    end
  end

endmodule

FILE: src/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value cache with lru replacement
// a chain of lrukv_cell entries plus the entry count and the result register
// depends on lrukv_pkg and lrukv_cell
//
// usage:
//   request channel (request_valid/request_stall) carries operation, key and
//   write_value; operation is get or put. result channel (result_valid/
//   result_stall) carries hit, read_value and evicted, one item per request.
//   config channel (config_valid/config_ready) writes capacity_in_use; it is
//   always ready. the user must write it only while the cache is idle; the
//   block does not enforce this. timing: the result is registered and shows in
//   the cycle after the request is taken. throughput: one item per cycle while
//   the result is not stalled; all entries compare the key in parallel and update ranks in the same cycle.
// stall: a stalled result holds, and request_stall rises while a result is
//   held, so nothing is lost or reordered.
// reset: all entries become empty, the count clears, capacity_in_use = 16.
//   there is no clearing pass; requests are taken right after reset.
module lru_key_value_cache
  import lrukv_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      request_valid,
  output logic                      request_stall,
  input  logic                      operation,
  input  logic signed [KEY_W-1:0]   key,
  input  logic signed [VALUE_W-1:0] write_value,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic                      hit,
  output logic signed [VALUE_W-1:0] read_value,
  output logic                      evicted,
  input  logic                      config_valid,
  output logic                      config_ready,
  input  logic [CFG_W-1:0]          config_data
);

  localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0] capacity_in_use;
  logic [CNT_W-1:0] count;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;

  logic        accept;
  logic        full;
  logic        lookup_hit;
  logic        insert;
  lrukv_req_t  req;
  lrukv_upd_t  upd;
  logic [RANK_W-1:0] last_rank;

  lrukv_link_t       link [0:CAPACITY];
  logic [RANK_W-1:0] rank_link [0:CAPACITY];
  logic [CAPACITY-1:0] occupied;

  assign config_ready  = 1'b1;
  assign request_stall = result_valid && result_stall;
  assign accept        = request_valid && !request_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CFG_RESET;
    end else if (config_valid && config_ready) begin
      capacity_in_use <= config_data;
    end
  end

  // zero acts as one, anything above CAPACITY saturates to CAPACITY
  assign cap_ext = CMP_W'(capacity_in_use);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      eff_cap = CMP_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full      = CMP_W'(count) >= eff_cap;
  assign last_rank = RANK_W'(count - CNT_W'(1));

  assign req.is_put      = (operation == OP_PUT);
  assign req.key         = key;
  assign req.write_value = write_value;

  assign link[0]      = '0;
  assign rank_link[0] = '0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      lrukv_cell #(
        .RANK_W(RANK_W)
      ) u_cell (
        .clk       (clk),
        .rst       (rst),
        .req       (req),
        .upd       (upd),
        .limit     (rank_link[CAPACITY]),
        .last_rank (last_rank),
        .link_in   (link[g]),
        .link_out  (link[g+1]),
        .rank_in   (rank_link[g]),
        .rank_out  (rank_link[g+1]),
        .occupied  (occupied[g])
      );
    end
  endgenerate

  assign lookup_hit = link[CAPACITY].hit;
  assign insert     = req.is_put && !lookup_hit;

  assign upd.go     = accept;
  assign upd.hit    = lookup_hit;
  assign upd.insert = insert;
  assign upd.full   = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && insert && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hit        <= lookup_hit;
      read_value <= (!req.is_put && lookup_hit) ? link[CAPACITY].value : MISS_VALUE;
      evicted    <= insert && full;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(occupied) == 32'(count))
    else $error("entry count disagrees with valid entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("entry count above capacity");

  a_evict_not_hit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && evicted))
    else $error("eviction flagged on a hit");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (accept && insert && full) |=> $stable(count))
    else $error("count changed on eviction");

endmodule
